[sv/lcgsr_pkg.sv]
package lcgsr_pkg;

    // Generator constants
    localparam logic [31:0] FWD_MULT_1 = 32'h41C64E6D;
    localparam logic [31:0] FWD_ADD_1  = 32'h00006073;
    localparam logic [31:0] FWD_MULT_2 = 32'hC2A29A69;
    localparam logic [31:0] FWD_ADD_2  = 32'hE97E7B6A;
    localparam logic [31:0] BACK_MULT  = 32'hEEB9EB65;
    localparam logic [31:0] BACK_ADD   = 32'h0A3561A1;

    // Candidate search constants
    localparam logic [14:0] STRIDE_1   = 15'h67D3;
    localparam logic [14:0] STRIDE_2   = 15'h3A89;
    localparam logic [13:0] PATTERN_1  = 14'h0D3E;
    localparam logic [13:0] PATTERN_2  = 14'h2E4C;
    localparam logic [31:0] OFFSET_1   = 32'h00004034;
    localparam logic [31:0] OFFSET_2   = 32'h05259D3A;

    // floor(2^32 / stride): quotient estimate is exact or one short
    localparam int          RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] RECIP_1 =
        RECIP_W'(64'h1_0000_0000 / 64'(STRIDE_1));
    localparam logic [RECIP_W-1:0] RECIP_2 =
        RECIP_W'(64'h1_0000_0000 / 64'(STRIDE_2));

    // Method codes
    localparam logic [1:0] METHOD_SINGLE   = 2'd0;
    localparam logic [1:0] METHOD_TWO_STEP = 2'd1;
    localparam logic [1:0] METHOD_EXTRA    = 2'd2;

    // Slot schedule: four top-bit choices, five low-half candidates each
    localparam logic [1:0] CHOICE_LAST = 2'd3;
    localparam logic [2:0] K_LAST      = 3'd4;

    localparam int PIPE_DEPTH = 12;

    typedef struct packed {
        logic        valid;
        logic        item_end;
        logic        two_step;
        logic        extra_back;
        logic        event_only;
        logic [15:0] s1hi;
        logic [15:0] s2hi;
        logic [2:0]  k;
        logic [16:0] kd;
        logic [15:0] diff;
        logic [15:0] t;
        logic [29:0] x;
        logic [16:0] qe;
        logic [15:0] r;
        logic        in_range;
        logic [31:0] cand;
        logic        hit;
        logic [31:0] seed;
    } pipe_t;

    function automatic logic [14:0] stride_of(input logic two_step);
        return two_step ? STRIDE_2 : STRIDE_1;
    endfunction

    function automatic logic [13:0] pattern_of(input logic two_step);
        return two_step ? PATTERN_2 : PATTERN_1;
    endfunction

    function automatic logic [31:0] offset_of(input logic two_step);
        return two_step ? OFFSET_2 : OFFSET_1;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input logic two_step);
        return two_step ? RECIP_2 : RECIP_1;
    endfunction

    function automatic logic [31:0] mult_of(input logic two_step);
        return two_step ? FWD_MULT_2 : FWD_MULT_1;
    endfunction

    function automatic logic [31:0] add_of(input logic two_step);
        return two_step ? FWD_ADD_2 : FWD_ADD_1;
    endfunction

    // One generator step backward, mod 2^32
    function automatic logic [31:0] step_back(input logic [31:0] s);
        logic [31:0] p;
        p = s * BACK_MULT;
        return p + BACK_ADD;
    endfunction

endpackage

[sv/lcgsr_query_if.sv]
interface lcgsr_query_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_high_half;
    logic [15:0] second_high_half;
    logic [1:0]  method;
    logic        event_only;

    modport source (
        output valid, first_high_half, second_high_half, method, event_only,
        input  ready
    );
    modport sink (
        input  valid, first_high_half, second_high_half, method, event_only,
        output ready
    );
endinterface

[sv/lcgsr_result_if.sv]
interface lcgsr_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;
    logic        found;
    logic        last;

    modport source (
        output valid, seed, found, last,
        input  ready
    );
    modport sink (
        input  valid, seed, found, last,
        output ready
    );
endinterface

[sv/lcg_seed_recovery_top.sv]
// LCG seed recovery from two observed upper halves.
// query channel: one item = first/second upper halves, method, event_only.
// result channel: one item per recovered seed in search order (top-bit
//   choice outer, ascending low half inner), last set on the final one;
//   when nothing survives, a single item with found=0, seed=0, last=1.
// The sequencer issues 20 candidate slots (4 top-bit choices x 5 low
//   halves) into a 12-stage pipeline, one slot per cycle while the
//   pipeline is not stalled; the next query is taken as the last slot
//   of the current one issues.
// A one-entry hold register keeps the latest kept seed until the next
//   one (or the end of the item) shows whether it is the last.
// Stall: when a result waits and result.ready is low, the whole pipeline
//   and the sequencer freeze; nothing is lost or repeated.
// Reset (rst_n low, async) clears the sequencer, stage valid bits, the
//   valid flags of the hold and output registers; no results are pending.
module lcg_seed_recovery_top (
    input  logic                  clk,
    input  logic                  rst_n,
    lcgsr_query_if.sink           query,
    lcgsr_result_if.source        result
);

    // ---------------------------------------------------------------
    // Global advance: whole pipeline moves when the output can take
    // a new item.
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic en;
    assign en = !out_valid_reg || result.ready;

    // ---------------------------------------------------------------
    // Slot sequencer
    // ---------------------------------------------------------------
    logic        busy_reg;
    logic [1:0]  choice_reg;
    logic [2:0]  k_reg;
    logic [15:0] first_reg;
    logic [15:0] second_reg;
    logic        two_step_reg;
    logic        extra_reg;
    logic        event_reg;
    logic        slot_last;
    logic        accept;

    assign slot_last    = (choice_reg == lcgsr_pkg::CHOICE_LAST) &&
                          (k_reg == lcgsr_pkg::K_LAST);
    assign query.ready  = !busy_reg || (slot_last && en);
    assign accept       = query.valid && query.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            choice_reg <= '0;
            k_reg      <= '0;
        end
        else if (accept)
        begin
            busy_reg   <= 1'b1;
            choice_reg <= '0;
            k_reg      <= '0;
        end
        else if (en && busy_reg)
        begin
            if (slot_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (k_reg == lcgsr_pkg::K_LAST)
            begin
                k_reg      <= '0;
                choice_reg <= choice_reg + 2'd1;
            end
            else
            begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    // Query payload; method 3 behaves like the single-step method
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg    <= query.first_high_half;
            second_reg   <= query.second_high_half;
            two_step_reg <= (query.method == lcgsr_pkg::METHOD_TWO_STEP);
            extra_reg    <= (query.method == lcgsr_pkg::METHOD_EXTRA);
            event_reg    <= query.event_only;
        end
    end

    // ---------------------------------------------------------------
    // Candidate pipeline
    //  0 issue      1 diff, k*stride   2 t           3 x = t*pattern
    //  4 quotient   5 remainder        6 candidate   7 forward check
    //  8..10 three backward steps      11 optional fourth step
    // ---------------------------------------------------------------
    lcgsr_pkg::pipe_t st_reg  [lcgsr_pkg::PIPE_DEPTH];
    lcgsr_pkg::pipe_t st_next [lcgsr_pkg::PIPE_DEPTH];

    logic [31:0] s1_prod;
    logic [31:0] t_prod;
    logic [48:0] q_prod;
    logic [31:0] qd_prod;
    logic [15:0] low_mod;
    logic [17:0] low_sum;
    logic [31:0] fwd_prod;
    logic [31:0] fwd_next;

    always_comb
    begin
        // Stage 0: issue one slot
        st_next[0]            = '0;
        st_next[0].valid      = busy_reg;
        st_next[0].item_end   = slot_last;
        st_next[0].two_step   = two_step_reg;
        st_next[0].extra_back = extra_reg;
        st_next[0].event_only = event_reg;
        st_next[0].s1hi       = first_reg  | {choice_reg[0], 15'd0};
        st_next[0].s2hi       = second_reg | {choice_reg[1], 15'd0};
        st_next[0].k          = k_reg;

        for (int i = 1; i < lcgsr_pkg::PIPE_DEPTH; i++)
        begin
            st_next[i] = st_reg[i-1];
        end

        // Stage 1: upper half of s2 - s1*mult (s1 low half is zero)
        s1_prod = 32'(st_reg[0].s1hi) *
                  32'(lcgsr_pkg::mult_of(st_reg[0].two_step) & 32'h0000_FFFF);
        st_next[1].diff = st_reg[0].s2hi - s1_prod[15:0];
        st_next[1].kd   = 17'(st_reg[0].k) *
                          17'(lcgsr_pkg::stride_of(st_reg[0].two_step));

        // Stage 2: t = (diff*stride + offset) >> 16
        t_prod = 32'(st_reg[1].diff) * 32'(lcgsr_pkg::stride_of(st_reg[1].two_step))
                 + lcgsr_pkg::offset_of(st_reg[1].two_step);
        st_next[2].t = t_prod[31:16];

        // Stage 3: x = t*pattern (< 2^30, no wrap)
        st_next[3].x = 30'(st_reg[2].t) * 30'(lcgsr_pkg::pattern_of(st_reg[2].two_step));

        // Stage 4: quotient estimate by reciprocal
        q_prod = 49'(st_reg[3].x) * 49'(lcgsr_pkg::recip_of(st_reg[3].two_step));
        st_next[4].qe = q_prod[48:32];

        // Stage 5: remainder, below twice the stride
        qd_prod = 32'(st_reg[4].qe) * 32'(lcgsr_pkg::stride_of(st_reg[4].two_step));
        st_next[5].r = 16'(st_reg[4].x - qd_prod[29:0]);

        // Stage 6: correct remainder, add k strides, build candidate
        if (st_reg[5].r >= 16'(lcgsr_pkg::stride_of(st_reg[5].two_step)))
        begin
            low_mod = st_reg[5].r - 16'(lcgsr_pkg::stride_of(st_reg[5].two_step));
        end
        else
        begin
            low_mod = st_reg[5].r;
        end
        low_sum = 18'(low_mod) + 18'(st_reg[5].kd);
        st_next[6].in_range = (low_sum[17:16] == 2'd0);
        st_next[6].cand     = {st_reg[5].s1hi, low_sum[15:0]};

        // Stage 7: forward step must reproduce the second upper half
        fwd_prod = st_reg[6].cand * lcgsr_pkg::mult_of(st_reg[6].two_step);
        fwd_next = fwd_prod + lcgsr_pkg::add_of(st_reg[6].two_step);
        st_next[7].hit = st_reg[6].in_range && (fwd_next[31:16] == st_reg[6].s2hi);

        // Stages 8..10: three backward steps
        st_next[8].seed  = lcgsr_pkg::step_back(st_reg[7].cand);
        st_next[9].seed  = lcgsr_pkg::step_back(st_reg[8].seed);
        st_next[10].seed = lcgsr_pkg::step_back(st_reg[9].seed);

        // Stage 11: fourth step for the extra-step method
        if (st_reg[10].extra_back)
        begin
            st_next[11].seed = lcgsr_pkg::step_back(st_reg[10].seed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcgsr_pkg::PIPE_DEPTH; i++)
            begin
                st_reg[i].valid <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < lcgsr_pkg::PIPE_DEPTH; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Result ordering: hold the latest kept seed until it is known
    // whether another follows for the same item.
    // ---------------------------------------------------------------
    lcgsr_pkg::pipe_t tail;
    logic        keep;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_final_reg, pend_final_next;
    logic [31:0] pend_seed_reg,  pend_seed_next;
    logic        out_valid_next;
    logic [31:0] seed_reg,  seed_next;
    logic        found_reg, found_next;
    logic        last_reg,  last_next;

    assign tail = st_reg[lcgsr_pkg::PIPE_DEPTH-1];
    assign keep = tail.valid && tail.hit &&
                  (!tail.event_only || (tail.seed[31:16] == 16'd0));

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_seed_next  = pend_seed_reg;
        out_valid_next  = 1'b0;
        seed_next       = '0;
        found_next      = 1'b0;
        last_next       = 1'b0;

        if (pend_final_reg)
        begin
            // flush the last seed of the previous item
            out_valid_next  = 1'b1;
            seed_next       = pend_seed_reg;
            found_next      = 1'b1;
            last_next       = 1'b1;
            pend_valid_next = keep;
            pend_final_next = 1'b0;
            pend_seed_next  = tail.seed;
        end
        else if (keep)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                seed_next       = pend_seed_reg;
                found_next      = 1'b1;
                pend_seed_next  = tail.seed;
                pend_final_next = tail.item_end;
            end
            else if (tail.item_end)
            begin
                out_valid_next = 1'b1;
                seed_next      = tail.seed;
                found_next     = 1'b1;
                last_next      = 1'b1;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_seed_next  = tail.seed;
            end
        end
        else if (tail.valid && tail.item_end)
        begin
            // item done: close out the held seed, or report none found
            out_valid_next  = 1'b1;
            seed_next       = pend_valid_reg ? pend_seed_reg : 32'd0;
            found_next      = pend_valid_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pend_seed_reg <= pend_seed_next;
            seed_reg      <= seed_next;
            found_reg     <= found_next;
            last_reg      <= last_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.seed  = seed_reg;
    assign result.found = found_reg;
    assign result.last  = last_reg;

endmodule

[sv/lcgsr_checker.sv]
module lcgsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        q_valid,
    input logic        q_ready,
    input logic        r_valid,
    input logic        r_ready,
    input logic [31:0] r_seed,
    input logic        r_found,
    input logic        r_last
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> (r_valid && $stable(r_seed) &&
                                   $stable(r_found) && $stable(r_last)))
        else $error("result changed while stalled");

    // a not-found result closes its item and carries a zero seed
    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_found) |-> (r_last && (r_seed == 32'd0)))
        else $error("not-found result without last or with nonzero seed");

    // an accepted query keeps the sequencer busy for the next cycles
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> !q_ready)
        else $error("query taken on consecutive cycles");

    // no result can appear right after reset without a query
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !r_valid)
        else $error("result valid straight out of reset");

endmodule

bind lcg_seed_recovery_top lcgsr_checker u_lcgsr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (query.valid),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_seed  (result.seed),
    .r_found (result.found),
    .r_last  (result.last)
);

[tb/lcg_seed_recovery_top_tb.sv]
module lcg_seed_recovery_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Generator and search constants, kept local so the prediction stands on its own
    localparam logic [31:0] LCG_MULT        = 32'h41C64E6D;
    localparam logic [31:0] LCG_INC         = 32'h00006073;
    localparam logic [31:0] SKIP_MULT       = 32'hC2A29A69;
    localparam logic [31:0] SKIP_INC        = 32'hE97E7B6A;
    localparam logic [31:0] REV_MULT        = 32'hEEB9EB65;
    localparam logic [31:0] REV_INC         = 32'h0A3561A1;
    localparam logic [31:0] SEARCH_STRIDE_A = 32'h000067D3;
    localparam logic [31:0] SEARCH_STRIDE_B = 32'h00003A89;
    localparam logic [31:0] SEARCH_PAT_A    = 32'h00000D3E;
    localparam logic [31:0] SEARCH_PAT_B    = 32'h00002E4C;
    localparam logic [31:0] SEARCH_OFS_A    = 32'h00004034;
    localparam logic [31:0] SEARCH_OFS_B    = 32'h05259D3A;

    // Code 3 has no meaning of its own; the block treats it as a single step
    localparam logic [1:0] METHOD_UNUSED = 2'd3;

    localparam int MAX_SEEDS_PER_QUERY = 20;
    localparam int RANDOM_PER_PHASE    = 22;
    localparam int HOLD_PHASE_ITEMS    = 20;
    localparam int LONG_HOLD_CYCLES    = 300;
    // Quiet time after the last drain, so that any stray result gets flagged
    localparam int DRAIN_CYCLES        = 60;
    // Longest legal quiet stretch is the long receiver hold; allow several times that
    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int MAX_REPORTS         = 10;

    typedef struct {
        logic [15:0] first_high_half;
        logic [15:0] second_high_half;
        logic [1:0]  method;
        logic        event_only;
    } query_t;

    typedef struct {
        logic [31:0] seed;
        logic        found;
        logic        last;
    } seed_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lcgsr_query_if  query_ch ();
    lcgsr_result_if result_ch ();

    lcg_seed_recovery_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    query_t       pending_queries[$];
    seed_result_t expected_seeds[$];

    // Handshake pacing, set per phase by the stimulus process
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit long_hold_req   = 1'b0;
    int hold_left       = 0;

    bit query_taken  = 1'b0;
    bit result_taken = 1'b0;

    int queries_accepted = 0;
    int results_seen     = 0;
    int seeds_found      = 0;
    int misses           = 0;
    int error_count      = 0;
    int stuck_cycles     = 0;
    int directed_items   = 0;

    function automatic logic [31:0] step_prior(input logic [31:0] s);
        return s * REV_MULT + REV_INC;
    endfunction

    // Search all four top-bit choices and their candidate low halves, keep the
    // candidates whose forward step lands on the second upper half, and queue
    // the seeds they lead back to (below 2^16 in event mode) in search order, or one not-found entry.
    function automatic void predict_recovered_seeds(input query_t q);
        logic [31:0] mult, inc, stride, pattern, offset;
        logic [31:0] s1, s2, diff, t, low, cand, nxt, seed;
        logic two_step, extra;
        seed_result_t hits[$];
        seed_result_t r;
        two_step = (q.method == lcgsr_pkg::METHOD_TWO_STEP);
        extra    = (q.method == lcgsr_pkg::METHOD_EXTRA);
        mult     = two_step ? SKIP_MULT : LCG_MULT;
        inc      = two_step ? SKIP_INC : LCG_INC;
        stride   = two_step ? SEARCH_STRIDE_B : SEARCH_STRIDE_A;
        pattern  = two_step ? SEARCH_PAT_B : SEARCH_PAT_A;
        offset   = two_step ? SEARCH_OFS_B : SEARCH_OFS_A;
        for (int c = 0; c < 4; c++) begin
            s1 = {q.first_high_half, 16'h0000};
            s2 = {q.second_high_half, 16'h0000};
            if (c[0])
                s1[31] = 1'b1;
            if (c[1])
                s2[31] = 1'b1;
            diff = (s2 - s1 * mult) >> 16;
            t    = (diff * stride + offset) >> 16;
            low  = (t * pattern) % stride;
            do
            begin
                cand = s1 | low;
                nxt  = cand * mult + inc;
                if (nxt[31:16] == s2[31:16])
                begin
                    seed = step_prior(step_prior(step_prior(cand)));
                    if (extra)
                        seed = step_prior(seed);
                    if ((!q.event_only || seed < 32'h0001_0000) &&
                        hits.size() < MAX_SEEDS_PER_QUERY)
                    begin
                        r.seed  = seed;
                        r.found = 1'b1;
                        r.last  = 1'b0;
                        hits.push_back(r);
                    end
                end
                low = low + stride;
            end
            while (low < 32'h0001_0000);
        end
        if (hits.size() == 0)
        begin
            r.seed  = 32'h0;
            r.found = 1'b0;
            r.last  = 1'b1;
            hits.push_back(r);
        end
        else
            hits[hits.size() - 1].last = 1'b1;
        foreach (hits[i])
            expected_seeds.push_back(hits[i]);
    endfunction

    function automatic query_t make_query(input logic [15:0] a, input logic [15:0] b,
                                          input logic [1:0] method, input logic ev);
        query_t q;
        q.first_high_half  = a;
        q.second_high_half = b;
        q.method           = method;
        q.event_only       = ev;
        return q;
    endfunction

    // Run the generator forward from a seed and report the two upper halves the
    // block would see, so that the search has a genuine match to find.
    function automatic query_t observe_from_seed(input logic [31:0] seed,
                                                 input logic [1:0] method,
                                                 input logic ev);
        logic [31:0] state, nxt;
        state = seed;
        repeat ((method == lcgsr_pkg::METHOD_EXTRA) ? 4 : 3)
            state = state * LCG_MULT + LCG_INC;
        if (method == lcgsr_pkg::METHOD_TWO_STEP)
            nxt = state * SKIP_MULT + SKIP_INC;
        else
            nxt = state * LCG_MULT + LCG_INC;
        return make_query(state[31:16], nxt[31:16], method, ev);
    endfunction

    // Mostly genuine generator outputs with random seeds; the rest is noise
    function automatic query_t random_query();
        logic [1:0] method;
        logic       ev;
        method = 2'($urandom_range(3));
        if ($urandom_range(99) < 70)
        begin
            ev = ($urandom_range(2) == 0);
            if (ev)
                return observe_from_seed(32'($urandom_range(65535)), method, ev);
            return observe_from_seed($urandom(), method, ev);
        end
        ev = 1'($urandom_range(1));
        return make_query(16'($urandom()), 16'($urandom()), method, ev);
    endfunction

    // Query driver: a new item goes out only once the current one was taken;
    // an offered item stays on the bus until accepted.
    always @(negedge clk)
    begin
        query_t nxt_q;
        if (rst_n)
        begin
            if (!query_ch.valid || query_taken)
            begin
                if (pending_queries.size() != 0 &&
                    !(sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct))
                begin
                    nxt_q = pending_queries.pop_front();
                    query_ch.first_high_half  <= nxt_q.first_high_half;
                    query_ch.second_high_half <= nxt_q.second_high_half;
                    query_ch.method           <= nxt_q.method;
                    query_ch.event_only       <= nxt_q.event_only;
                    query_ch.valid            <= 1'b1;
                end
                else
                    query_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(recv_stall_pct > 0 &&
                                     $urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on every accepted query, check every accepted result
    // against the oldest expectation, and watch for a hung handshake.
    always @(posedge clk)
    begin
        query_t       taken_q;
        seed_result_t want;
        if (rst_n)
        begin
            query_taken = query_ch.valid && query_ch.ready;
            if (query_taken)
            begin
                taken_q.first_high_half  = query_ch.first_high_half;
                taken_q.second_high_half = query_ch.second_high_half;
                taken_q.method           = query_ch.method;
                taken_q.event_only       = query_ch.event_only;
                predict_recovered_seeds(taken_q);
                queries_accepted++;
            end

            result_taken = result_ch.valid && result_ch.ready;
            if (result_taken)
            begin
                results_seen++;
                if (result_ch.found)
                    seeds_found++;
                else
                    misses++;
                if (expected_seeds.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: seed %h found %b last %b",
                                 result_ch.seed, result_ch.found, result_ch.last);
                end
                else
                begin
                    want = expected_seeds.pop_front();
                    if (result_ch.seed !== want.seed || result_ch.found !== want.found ||
                        result_ch.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("result %0d: expected seed %h found %b last %b, %s",
                                     results_seen, want.seed, want.found, want.last,
                                     $sformatf("got seed %h found %b last %b",
                                               result_ch.seed, result_ch.found,
                                               result_ch.last));
                    end
                end
            end

            if (query_taken || result_taken)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stuck_cycles, expected_seeds.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Sample just after the edge so the monitor and driver updates have settled.
    // With drain_results set, also wait until every expected result has come.
    task automatic wait_idle(input bit drain_results);
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_queries.size() != 0 || query_ch.valid ||
               (drain_results && expected_seeds.size() != 0));
    endtask

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 66, 0, 9};
        recv_pct = '{0, 0, 66, 9};

        rst_n                     = 1'b0;
        query_ch.valid            = 1'b0;
        query_ch.first_high_half  = 16'h0;
        query_ch.second_high_half = 16'h0;
        query_ch.method           = lcgsr_pkg::METHOD_SINGLE;
        query_ch.event_only       = 1'b0;
        result_ch.ready           = 1'b0;
        repeat (3) @(posedge clk);
        #1 rst_n = 1'b1;

        // Directed: field extremes under every method code
        pending_queries.push_back(make_query(16'h0000, 16'h0000,
                                             lcgsr_pkg::METHOD_SINGLE, 1'b0));
        pending_queries.push_back(make_query(16'h0000, 16'h0000,
                                             lcgsr_pkg::METHOD_TWO_STEP, 1'b0));
        pending_queries.push_back(make_query(16'h0000, 16'h0000,
                                             lcgsr_pkg::METHOD_EXTRA, 1'b0));
        pending_queries.push_back(make_query(16'h0000, 16'h0000, METHOD_UNUSED, 1'b0));
        pending_queries.push_back(make_query(16'hFFFF, 16'hFFFF,
                                             lcgsr_pkg::METHOD_SINGLE, 1'b0));
        pending_queries.push_back(make_query(16'hFFFF, 16'hFFFF,
                                             lcgsr_pkg::METHOD_TWO_STEP, 1'b1));
        pending_queries.push_back(make_query(16'h0000, 16'hFFFF,
                                             lcgsr_pkg::METHOD_EXTRA, 1'b1));
        pending_queries.push_back(make_query(16'hFFFF, 16'h0000, METHOD_UNUSED, 1'b0));
        pending_queries.push_back(make_query(16'h8000, 16'h7FFF,
                                             lcgsr_pkg::METHOD_SINGLE, 1'b1));
        pending_queries.push_back(make_query(16'h7FFF, 16'h8000,
                                             lcgsr_pkg::METHOD_TWO_STEP, 1'b0));
        pending_queries.push_back(make_query(16'hAAAA, 16'h5555,
                                             lcgsr_pkg::METHOD_EXTRA, 1'b0));
        pending_queries.push_back(make_query(16'h5555, 16'hAAAA, METHOD_UNUSED, 1'b1));
        // Genuine outputs: seed extremes, the event-mode bound on both sides,
        // the extra backward step, and the meaningless method code
        pending_queries.push_back(observe_from_seed(32'h0000_0000,
                                                    lcgsr_pkg::METHOD_SINGLE, 1'b1));
        pending_queries.push_back(observe_from_seed(32'h0000_FFFF,
                                                    lcgsr_pkg::METHOD_EXTRA, 1'b1));
        pending_queries.push_back(observe_from_seed(32'hFFFF_FFFF,
                                                    lcgsr_pkg::METHOD_TWO_STEP, 1'b0));
        pending_queries.push_back(observe_from_seed(32'h0001_0000,
                                                    lcgsr_pkg::METHOD_SINGLE, 1'b1));
        pending_queries.push_back(observe_from_seed(32'h0000_1234, METHOD_UNUSED, 1'b1));
        pending_queries.push_back(observe_from_seed($urandom(),
                                                    lcgsr_pkg::METHOD_EXTRA, 1'b0));
        pending_queries.push_back(observe_from_seed(32'h0000_FFFF,
                                                    lcgsr_pkg::METHOD_TWO_STEP, 1'b1));
        pending_queries.push_back(observe_from_seed(32'h8000_0001,
                                                    lcgsr_pkg::METHOD_SINGLE, 1'b0));
        directed_items = pending_queries.size();

        // Sender holds back until every directed result is home
        wait_idle(1'b1);

        // Random phases: free-running, sender gaps, receiver stalls, light both
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = send_pct[p];
            recv_stall_pct  = recv_pct[p];
            repeat (RANDOM_PER_PHASE)
                pending_queries.push_back(random_query());
            wait_idle(1'b0);
        end

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the pipeline fills and the query side has to stall
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (HOLD_PHASE_ITEMS)
            pending_queries.push_back(random_query());
        long_hold_req = 1'b1;
        wait_idle(1'b1);

        // Anything the block emits after this point is flagged as unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d queries (%0d directed), five pacing phases, long result hold",
                 queries_accepted, directed_items);
        $display("checked %0d results: %0d seeds, %0d not found, %0d mismatches",
                 results_seen, seeds_found, misses, error_count);
        if (error_count == 0 && expected_seeds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/lcgsr_pkg.sv
sv/lcgsr_query_if.sv
sv/lcgsr_result_if.sv
sv/lcg_seed_recovery_top.sv
sv/lcgsr_checker.sv
tb/lcg_seed_recovery_top_tb.sv
